>>> design/vcxy_pkg.sv
`default_nettype none
package vcxy_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned OFFSET_W = 7;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned MASK_W   = 2;
  localparam int unsigned IDX_W    = 5;

  // Request codes.
  localparam logic [FUNC_W-1:0] FUNC_REG_WR = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REG_RD = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_XY_WR  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_XY_RD  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd4;

  // Register indexes with side effects.
  localparam logic [IDX_W-1:0] R_VERINT    = 5'd10;
  localparam logic [IDX_W-1:0] R_CONTROL1  = 5'd11;
  localparam logic [IDX_W-1:0] R_CONTROL2  = 5'd12;
  localparam logic [IDX_W-1:0] R_STATUS    = 5'd13;
  localparam logic [IDX_W-1:0] R_XYADDRESS = 5'd15;

  localparam int unsigned CTRL1_VINT_EN_BIT = 10;
  localparam int unsigned CTRL2_DISP_EN_BIT = 13;
  localparam logic [WORD_W-1:0] STATUS_VINT = 16'h0001;

  // Coordinate adjust codes.
  localparam logic [1:0] STEP_KEEP = 2'd0;
  localparam logic [1:0] STEP_INC  = 2'd1;
  localparam logic [1:0] STEP_DEC  = 2'd2;
  localparam logic [1:0] STEP_ZERO = 2'd3;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } bank_wr_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              supported;
    logic [BYTE_W-1:0] pixel_x;
    logic [BYTE_W-1:0] pixel_y;
    logic              pixel_write;
    logic              pixel_read;
    logic [BYTE_W-1:0] pixel_data;
    logic              interrupt;
    logic              display_blanked;
  } result_t;

  // Power-on defaults of the register bank.
  function automatic logic [WORD_W-1:0] reset_value(input logic [IDX_W-1:0] idx);
    logic [WORD_W-1:0] v;
    case (idx)
      5'd0:    v = 16'h0010;
      5'd1:    v = 16'h0020;
      5'd2:    v = 16'h01f0;
      5'd3:    v = 16'h0200;
      5'd4:    v = 16'h0004;
      5'd5:    v = 16'h0010;
      5'd6:    v = 16'h00f0;
      5'd7:    v = 16'h0100;
      5'd11:   v = 16'h7000;
      5'd12:   v = 16'h0600;
      5'd14:   v = 16'h0010;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic logic [BYTE_W-1:0] step_coord(input logic [BYTE_W-1:0] c,
                                                   input logic [1:0] code);
    logic [BYTE_W-1:0] r;
    case (code)
      STEP_INC:  r = c + 8'd1;
      STEP_DEC:  r = c - 8'd1;
      STEP_ZERO: r = '0;
      default:   r = c;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/vcxy_in_if.sv
`default_nettype none
interface vcxy_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [6:0] offset;
  logic [7:0] data;

  modport source (output valid, output func, output offset, output data, input ready);
  modport sink   (input valid, input func, input offset, input data, output ready);
endinterface
`default_nettype wire

>>> design/vcxy_out_if.sv
`default_nettype none
interface vcxy_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       supported;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic       pixel_write;
  logic       pixel_read;
  logic [7:0] pixel_data;
  logic       interrupt;
  logic       display_blanked;

  modport source (output valid, output read_data, output supported, output pixel_x,
                  output pixel_y, output pixel_write, output pixel_read,
                  output pixel_data, output interrupt, output display_blanked,
                  input ready);
  modport sink   (input valid, input read_data, input supported, input pixel_x,
                  input pixel_y, input pixel_write, input pixel_read,
                  input pixel_data, input interrupt, input display_blanked,
                  output ready);
endinterface
`default_nettype wire

>>> design/vcxy_cfg_if.sv
`default_nettype none
interface vcxy_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/vcxy_bank.sv
`default_nettype none
module vcxy_bank #(
  parameter int unsigned NUM_REGS = 18
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rd_en,
  input  wire logic [vcxy_pkg::IDX_W-1:0]  rd_addr,
  input  wire vcxy_pkg::bank_wr_t          wr,
  output logic      [vcxy_pkg::WORD_W-1:0] rd_value
);
  import vcxy_pkg::*;

  localparam logic [IDX_W:0] DEPTH = (IDX_W + 1)'(NUM_REGS);

  logic [WORD_W-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0] written_r;

  logic [WORD_W-1:0] mem_rd_r;
  logic [IDX_W-1:0]  rd_addr_r;
  logic              rd_written_r;
  logic              fwd_hit_r;
  logic [WORD_W-1:0] fwd_data_r;
  logic              rd_in_range;
  logic              wr_in_range;

  assign rd_in_range = {1'b0, rd_addr} < DEPTH;
  assign wr_in_range = {1'b0, wr.addr} < DEPTH;

  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en && rd_in_range) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  // An entry never written since reset reads as its default.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr.en && wr_in_range) begin
      written_r[wr.addr] <= 1'b1;
    end
  end

  // A write landing on the same edge as the read is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_r    <= rd_addr;
      rd_written_r <= rd_in_range && written_r[rd_addr];
      fwd_hit_r    <= wr.en && (wr.addr == rd_addr);
      fwd_data_r   <= wr.data;
    end
  end

  always_comb begin
    if (fwd_hit_r) begin
      rd_value = fwd_data_r;
    end else if (rd_written_r) begin
      rd_value = mem_rd_r;
    end else begin
      rd_value = reset_value(rd_addr_r);
    end
  end

endmodule
`default_nettype wire

>>> design/vcxy_exec.sv
`default_nettype none
module vcxy_exec (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          advance,
  input  wire logic [vcxy_pkg::FUNC_W-1:0]   func,
  input  wire logic [vcxy_pkg::OFFSET_W-1:0] offset,
  input  wire logic [vcxy_pkg::BYTE_W-1:0]   data,
  input  wire logic                          hi,
  input  wire logic                          in_bank,
  input  wire logic [vcxy_pkg::WORD_W-1:0]   rd_value,
  output vcxy_pkg::bank_wr_t                 wr,
  output vcxy_pkg::result_t                  res
);
  import vcxy_pkg::*;

  localparam logic [WORD_W-1:0] CTRL1_RESET = reset_value(R_CONTROL1);
  localparam logic [WORD_W-1:0] CTRL2_RESET = reset_value(R_CONTROL2);

  // Copies of the two control bits that every request may need.
  logic vint_en_r;
  logic vint_en_nxt;
  logic disp_en_r;
  logic disp_en_nxt;

  logic [IDX_W-1:0]  reg_idx;
  logic [BYTE_W-1:0] x_cur;
  logic [BYTE_W-1:0] y_cur;

  assign reg_idx = offset[OFFSET_W-1:2];
  assign x_cur   = rd_value[BYTE_W-1:0];
  assign y_cur   = rd_value[WORD_W-1:BYTE_W];

  always_comb begin
    wr  = '0;
    res = '0;
    unique case (func) inside
      FUNC_REG_WR: begin
        if (in_bank) begin
          wr.en   = 1'b1;
          wr.addr = reg_idx;
          wr.data = hi ? {data, x_cur} : {y_cur, data};
          res.supported = (reg_idx == R_VERINT) || (reg_idx == R_CONTROL1) ||
                          (reg_idx == R_CONTROL2) || (reg_idx == R_XYADDRESS);
        end
      end
      FUNC_REG_RD: begin
        if (in_bank) begin
          res.read_data = hi ? y_cur : x_cur;
          if (reg_idx == R_STATUS) begin
            wr.en   = 1'b1;
            wr.addr = R_STATUS;
            wr.data = '0;
          end
          res.supported = (reg_idx == R_STATUS) || (reg_idx == R_CONTROL1) ||
                          (reg_idx == R_CONTROL2) || (reg_idx == R_XYADDRESS);
        end
      end
      FUNC_XY_WR, FUNC_XY_RD: begin
        res.pixel_x     = x_cur;
        res.pixel_y     = y_cur;
        res.pixel_write = (func == FUNC_XY_WR);
        res.pixel_read  = (func == FUNC_XY_RD);
        res.pixel_data  = (func == FUNC_XY_WR) ? data : '0;
        if (offset != '0) begin
          wr.en   = 1'b1;
          wr.addr = R_XYADDRESS;
          wr.data = {step_coord(y_cur, offset[4:3]), step_coord(x_cur, offset[2:1])};
        end
      end
      FUNC_TICK: begin
        if (vint_en_r) begin
          wr.en         = 1'b1;
          wr.addr       = R_STATUS;
          wr.data       = rd_value | STATUS_VINT;
          res.interrupt = 1'b1;
        end
      end
      default: begin
      end
    endcase

    vint_en_nxt = vint_en_r;
    disp_en_nxt = disp_en_r;
    if (wr.en && (wr.addr == R_CONTROL1)) begin
      vint_en_nxt = wr.data[CTRL1_VINT_EN_BIT];
    end
    if (wr.en && (wr.addr == R_CONTROL2)) begin
      disp_en_nxt = wr.data[CTRL2_DISP_EN_BIT];
    end
    res.display_blanked = !disp_en_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vint_en_r <= CTRL1_RESET[CTRL1_VINT_EN_BIT];
      disp_en_r <= CTRL2_RESET[CTRL2_DISP_EN_BIT];
    end else if (advance) begin
      vint_en_r <= vint_en_nxt;
      disp_en_r <= disp_en_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/video_controller_register_xy_access.sv
`default_nettype none
// Register side of a video controller. Each request on in_req is a byte-wide
// register write or read, an XY pixel write or read, or a frame tick, and it
// produces exactly one result on out_res, in request order. The 16-bit register
// bank lives in a synchronous memory: a request reads its register on the edge it
// is accepted, and the result is formed, written back and registered as it leaves
// the read stage. A write that meets a read of the same register on one edge is
// forwarded. A new request is accepted every cycle unless the output register is
// full and out_res.ready is low; then the result holds there and the request
// behind it waits in the read stage. Reset restores the manual defaults at once
// through per-register written flags, so no clearing pass is needed. cfg_wr sets
// the byte half-select mask and should be written only while idle.
module video_controller_register_xy_access #(
  parameter int unsigned NUM_REGS = 18
) (
  input  wire logic clk,
  input  wire logic rst_n,
  vcxy_in_if.sink   in_req,
  vcxy_out_if.source out_res,
  vcxy_cfg_if.sink  cfg_wr
);
  import vcxy_pkg::*;

  localparam logic [IDX_W:0] DEPTH = (IDX_W + 1)'(NUM_REGS);

  logic [MASK_W-1:0] half_mask_r;

  // Read stage: the request whose register is being fetched.
  logic                s1_valid_r;
  logic [FUNC_W-1:0]   s1_func_r;
  logic [OFFSET_W-1:0] s1_offset_r;
  logic [BYTE_W-1:0]   s1_data_r;
  logic                s1_hi_r;
  logic                s1_in_bank_r;

  // Output register.
  logic    out_valid_r;
  result_t res_r;

  logic             accept;
  logic             advance;
  logic [IDX_W-1:0] in_idx;
  logic [IDX_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_value;
  bank_wr_t         wr;
  result_t          res;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_mask_r <= '0;
    end else if (cfg_wr.valid) begin
      half_mask_r <= cfg_wr.data;
    end
  end

  assign advance      = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_req.ready = !s1_valid_r || advance;
  assign accept       = in_req.valid && in_req.ready;
  assign in_idx       = in_req.offset[OFFSET_W-1:2];

  // Pixel requests always work on the XY address, frame ticks on status.
  always_comb begin
    case (in_req.func) inside
      FUNC_XY_WR, FUNC_XY_RD: rd_addr = R_XYADDRESS;
      FUNC_TICK:              rd_addr = R_STATUS;
      default:                rd_addr = in_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r    <= in_req.func;
      s1_offset_r  <= in_req.offset;
      s1_data_r    <= in_req.data;
      s1_hi_r      <= (in_req.offset[MASK_W-1:0] & half_mask_r) != '0;
      s1_in_bank_r <= {1'b0, in_idx} < DEPTH;
    end
  end

  vcxy_bank #(
    .NUM_REGS (NUM_REGS)
  ) u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .rd_value (rd_value)
  );

  // Write-back only happens when the request moves on, so a stalled request
  // never updates the bank twice.
  bank_wr_t wr_gated;
  assign wr = wr_gated;

  bank_wr_t wr_exec;
  always_comb begin
    wr_gated    = wr_exec;
    wr_gated.en = wr_exec.en && advance;
  end

  vcxy_exec u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .func     (s1_func_r),
    .offset   (s1_offset_r),
    .data     (s1_data_r),
    .hi       (s1_hi_r),
    .in_bank  (s1_in_bank_r),
    .rd_value (rd_value),
    .wr       (wr_exec),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.read_data       = res_r.read_data;
  assign out_res.supported       = res_r.supported;
  assign out_res.pixel_x         = res_r.pixel_x;
  assign out_res.pixel_y         = res_r.pixel_y;
  assign out_res.pixel_write     = res_r.pixel_write;
  assign out_res.pixel_read      = res_r.pixel_read;
  assign out_res.pixel_data      = res_r.pixel_data;
  assign out_res.interrupt       = res_r.interrupt;
  assign out_res.display_blanked = res_r.display_blanked;

endmodule
`default_nettype wire
